// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the moving-average block.
// Depends on nothing; each macro takes the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: hdl/mcma_pkg.sv
// Package of the multichannel moving-average block: sizes, derived widths and payload types.
// Depends on nothing; imported by the top level.
package mcma_pkg;

	localparam int MAX_WINDOW = 128;
	localparam int CHANNELS   = 512;

	localparam int SAMPLE_W = 32;
	localparam int CHAN_W   = 9;
	localparam int WREG_W   = 8;
	localparam int SUM_W    = 34;

	// Effective window 1..MAX_WINDOW, and frame counter that saturates at it.
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int CH_AW      = $clog2(CHANNELS);
	localparam int RING_DEPTH = MAX_WINDOW * CHANNELS;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int DIV_CNT_W  = $clog2(SAMPLE_W);

	localparam logic signed [SUM_W-1:0] RES_MAX =
		{{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] RES_MIN = ~RES_MAX;

	typedef struct packed {
		logic [CHAN_W-1:0]          channel;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_last;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]          out_channel;
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       out_frame_last;
	} result_t;

endpackage

// File: hdl/mcma_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used for the quotient ring and the channel sums.
module mcma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/multichannel_moving_average_unit.sv
// Top level of the multichannel boxcar moving-average block.
// Depends on mcma_pkg, mcma_ram and assert_macros.svh.
`include "assert_macros.svh"

// Boxcar moving average over a frame of up to CHANNELS sensor channels. Each input transfer
// carries one channel sample; each produces exactly one result transfer, in order. A filtered
// sample is divided by the effective window (window_wdata clipped to 1..MAX_WINDOW), truncating
// toward zero, by a restoring divider that retires one quotient bit per cycle. The quotient is
// stored in the channel's slot of the quotient ring and added to the channel's running sum;
// once a full window of frames has been seen the quotient written one window earlier in that
// slot is subtracted. The result is the running sum saturated to 32 bits, so the first frames
// give partial sums. Channel 0, channels at or beyond CHANNELS and a window of 1 pass the sample
// through unchanged. The ring slot and frame count advance on frame_last when the window is
// above 1. A filtered item is accepted, runs 32 divider steps, reads the ring and sum memories
// (registered read), updates them and is saturated into the output register; a passed item
// goes from acceptance to the saturation step, which waits until the output register is free.
// Only one item is in flight; the next input transfer is taken once the current result is in
// the output register, even while that register waits on result_stall. After reset and after
// every write of the window register a clearing pass zeroes all CHANNELS entries (512 here)
// of the sum memory, during which no input is accepted. Configuration must be written only
// while the block is idle (not enforced by the block); a write during clearing restarts it.
module multichannel_moving_average_unit
	import mcma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              window_we,
	input  logic [WREG_W-1:0] window_wdata,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIV   = 6'b000100,
		S_RD    = 6'b001000,
		S_UPD   = 6'b010000,
		S_SAT   = 6'b100000
	} state_t;

	state_t state_q;

	// Window control state.
	logic [WIN_W-1:0]  eff_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WIN_W-1:0]  frames_q;
	logic [CH_AW-1:0]  clr_q;

	// Item being worked on.
	logic [CHAN_W-1:0]          chan_q;
	logic                       last_q;
	logic [CH_AW-1:0]           ch_addr_q;
	logic [RING_AW-1:0]         ring_addr_q;
	logic                       neg_q;
	logic [SAMPLE_W-1:0]        dvd_q;
	logic [WIN_W-1:0]           rem_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic signed [SAMPLE_W-1:0] quot_q;
	logic signed [SUM_W-1:0]    res_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	logic                     accept;
	logic                     filt;
	logic [SAMPLE_W-1:0]      mag;
	logic [SLOT_W-1:0]        slot_eff;
	logic [WIN_W:0]           trial;
	logic                     ge;
	logic [WIN_W-1:0]         rem_nxt;
	logic                     out_free;
	logic                     full;
	logic [WIN_W-1:0]         eff_nxt;
	logic [WIN_W-1:0]         slot_inc;

	logic                     sum_we;
	logic [CH_AW-1:0]         sum_waddr;
	logic [SUM_W-1:0]         sum_wdata;
	logic [SUM_W-1:0]         sum_rdata;
	logic [SAMPLE_W-1:0]      ring_rdata;
	logic signed [SUM_W-1:0]  sum_old;
	logic signed [SUM_W-1:0]  drop_ext;
	logic signed [SUM_W-1:0]  quot_ext;
	logic signed [SUM_W-1:0]  sum_new;
	logic [SAMPLE_W-1:0]      sat_val;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// The output register can take a result when empty or when its result leaves now.
	assign out_free = !out_valid_q || !result_stall;

	// Window register value clipped to the supported range.
	always_comb begin
		if (window_wdata == '0) begin
			eff_nxt = WIN_W'(1);
		end else if (32'(window_wdata) > MAX_WINDOW) begin
			eff_nxt = WIN_W'(MAX_WINDOW);
		end else begin
			eff_nxt = WIN_W'(window_wdata);
		end
	end

	// An item is filtered only for a real channel and a window above one.
	assign filt = (eff_q > WIN_W'(1)) && (item.channel != '0) &&
		(32'(item.channel) < CHANNELS);

	assign mag      = item.sample[SAMPLE_W-1] ? (~item.sample + 1'b1) : item.sample;
	assign slot_eff = (WIN_W'(slot_q) < eff_q) ? slot_q : '0;

	// One restoring-division step: the remainder always stays below the window.
	assign trial   = {rem_q, dvd_q[SAMPLE_W-1]};
	assign ge      = trial >= {1'b0, eff_q};
	assign rem_nxt = ge ? WIN_W'(trial - {1'b0, eff_q}) : trial[WIN_W-1:0];

	// Read-modify-write of the running sum; the ring entry is dropped once the window is full.
	assign full     = frames_q >= eff_q;
	assign sum_old  = signed'(sum_rdata);
	assign drop_ext = full ? SUM_W'(signed'(ring_rdata)) : '0;
	assign quot_ext = SUM_W'(quot_q);
	assign sum_new  = sum_old - drop_ext + quot_ext;

	assign sum_we    = (state_q == S_CLEAR) || (state_q == S_UPD);
	assign sum_waddr = (state_q == S_CLEAR) ? clr_q : ch_addr_q;
	assign sum_wdata = (state_q == S_CLEAR) ? '0 : sum_new;

	always_comb begin
		if (res_q > RES_MAX) begin
			sat_val = RES_MAX[SAMPLE_W-1:0];
		end else if (res_q < RES_MIN) begin
			sat_val = RES_MIN[SAMPLE_W-1:0];
		end else begin
			sat_val = res_q[SAMPLE_W-1:0];
		end
	end

	assign slot_inc = WIN_W'(slot_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			eff_q       <= WIN_W'(1);
			slot_q      <= '0;
			frames_q    <= '0;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == CH_AW'(CHANNELS - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= filt ? S_DIV : S_SAT;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (cnt_q == DIV_CNT_W'(SAMPLE_W - 1)) begin
						state_q <= S_RD;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						if ((eff_q > WIN_W'(1)) && last_q) begin
							slot_q <= (slot_inc >= eff_q) ? '0 : slot_inc[SLOT_W-1:0];
							if (frames_q < eff_q) begin
								frames_q <= frames_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A window write restarts the run from empty sums.
			if (window_we) begin
				eff_q    <= eff_nxt;
				slot_q   <= '0;
				frames_q <= '0;
				clr_q    <= '0;
				state_q  <= S_CLEAR;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q      <= item.channel;
			last_q      <= item.frame_last;
			ch_addr_q   <= CH_AW'(item.channel);
			ring_addr_q <= RING_AW'(slot_eff) * RING_AW'(CHANNELS) + RING_AW'(item.channel);
			neg_q       <= item.sample[SAMPLE_W-1];
			dvd_q       <= mag;
			rem_q       <= '0;
			res_q       <= SUM_W'(item.sample);
		end
		if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[SAMPLE_W-2:0], ge};
			rem_q <= rem_nxt;
		end
		if (state_q == S_RD) begin
			quot_q <= neg_q ? signed'(~dvd_q + 1'b1) : signed'(dvd_q);
		end
		if (state_q == S_UPD) begin
			res_q <= sum_new;
		end
		if ((state_q == S_SAT) && out_free) begin
			out_q.out_channel    <= chan_q;
			out_q.filtered       <= signed'(sat_val);
			out_q.out_frame_last <= last_q;
		end
	end

	mcma_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RING_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (state_q == S_UPD),
		.waddr(ring_addr_q),
		.wdata(quot_q),
		.raddr(ring_addr_q),
		.rdata(ring_rdata)
	);

	mcma_ram #(
		.WIDTH(SUM_W),
		.DEPTH(CHANNELS)
	) u_sum_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.raddr(ch_addr_q),
		.rdata(sum_rdata)
	);

	// The frame count never passes the window, and the ring slot stays inside it.
	`ASSERT_IMPLIES(a_frames_in_window, clk, arst_n, 1'b1, frames_q <= eff_q)
	`ASSERT_IMPLIES(a_slot_in_window, clk, arst_n, 1'b1, WIN_W'(slot_q) < eff_q)
	// After the last divider step the remainder is below the divisor.
	`ASSERT_IMPLIES(a_rem_below_window, clk, arst_n, state_q == S_RD, rem_q < eff_q)
	// A result is loaded only from the saturation step into a free output register.
	`ASSERT_NEXT(a_result_from_sat, clk, arst_n,
		(state_q == S_SAT) && out_free && !window_we, out_valid_q && (state_q == S_IDLE))

endmodule
